// ----- src/ssdg_pkg.sv -----
`default_nettype none
package ssdg_pkg;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] REG_SHARPEN_STRENGTH = 3'd0;
   localparam logic [CSR_AW-1:0] REG_DEHALO_STRENGTH  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_SIGMA_MIN_SQ     = 3'd2;
   localparam logic [CSR_AW-1:0] REG_SIGMA_MAX_SQ     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_HALO_FLOOR_SQ    = 3'd4;
   localparam logic [CSR_AW-1:0] REG_DEGRID_ENABLE    = 3'd5;

   localparam int REQ_DW = 184;
   localparam int RSP_DW = 64;

   // fraction divider: Q0.32 quotient, one bit per stage
   localparam int FRAC_DW = 32;
   localparam int FRAC_QW = 32;
   // dehalo gain divider: 2^40 / (2^28 + t), quotient at most 4096
   localparam int GD_DW = 33;
   localparam int GD_QW = 13;

endpackage
`default_nettype wire

// ----- src/ssdg_div.sv -----
`default_nettype none
module ssdg_div #(
   parameter int DW = ssdg_pkg::FRAC_DW,
   parameter int QW = ssdg_pkg::FRAC_QW
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] rem_in,
   input  logic [DW-1:0] den_in,
   output logic [QW-1:0] quot
);

   logic [DW-1:0] rem_ff [0:QW-1];
   logic [DW-1:0] den_ff [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW-1];
   logic [DW-1:0] rem_src [0:QW-1];
   logic [DW-1:0] den_src [0:QW-1];
   logic [QW-1:0] q_src   [0:QW-1];
   logic [DW-1:0] rem_in_a [0:QW-1];
   logic [QW-1:0] q_in     [0:QW-1];
   logic [DW:0]   dbl      [0:QW-1];

   always_comb begin
      rem_src[0] = rem_in;
      den_src[0] = den_in;
      q_src[0]   = '0;
      for (int j = 1; j < QW; j++) begin
         rem_src[j] = rem_ff[j-1];
         den_src[j] = den_ff[j-1];
         q_src[j]   = q_ff[j-1];
      end
      for (int j = 0; j < QW; j++) begin
         dbl[j] = {rem_src[j], 1'b0};
         if (dbl[j] >= {1'b0, den_src[j]}) begin
            rem_in_a[j] = DW'(dbl[j] - {1'b0, den_src[j]});
            q_in[j]     = QW'({q_src[j], 1'b1});
         end else begin
            rem_in_a[j] = DW'(dbl[j]);
            q_in[j]     = QW'({q_src[j], 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QW; j++) begin
            rem_ff[j] <= rem_in_a[j];
            den_ff[j] <= den_src[j];
            q_ff[j]   <= q_in[j];
         end
      end
   end

   assign quot = q_ff[QW-1];

endmodule
`default_nettype wire

// ----- src/spectral_sharpen_dehalo_gain_core.sv -----
// Frequency-domain sharpen / dehalo gain, one complex bin per transfer.
// req_* carries a bin with its grid sample, grid fraction and the two
// per-bin weights; rsp_* returns the scaled, saturated bin. Both channels
// are valid/ready streams; a transfer happens when tvalid and tready are
// both high at a rising clock edge.
// csr_* writes one of six registers (index = csr_addr) on any edge with
// csr_wen high; write only while no bin is in flight.
// The long path from the req transfer to rsp_tvalid is the 32-stage
// bit-per-stage fraction divider, followed by the 16-stage square root
// and the gain multipliers.
// Throughput: one bin per cycle while rsp_tready does not hold the pipeline.
// Reset (synchronous, active high) clears the six configuration registers and the pipeline
// valid bits; payload registers are not cleared.
// When rsp_tready is low with a result waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
`default_nettype none
module spectral_sharpen_dehalo_gain_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // bin_re, bin_im, grid_re, grid_im, grid_fraction, sharpen_weight, dehalo_weight
   input  logic [ssdg_pkg::REQ_DW-1:0]  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // result_re, result_im
   output logic [ssdg_pkg::RSP_DW-1:0]  rsp_tdata,
   input  logic                         csr_wen,
   input  logic [ssdg_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [ssdg_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int LAST = 60;

   function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
      if (x[41:31] != {11{x[41]}}) begin
         sat32 = x[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   function automatic logic [63:0] norm_pair(input logic [48:0] n, input logic [48:0] d);
      logic [4:0]  sel;
      logic [48:0] ns;
      logic [48:0] ds;
      sel = 5'd0;
      for (int k = 17; k >= 0; k--) begin
         if ((d >> k) <= 49'h0_FFFF_FFFF) sel = 5'(k);
      end
      ns = n >> sel;
      ds = d >> sel;
      norm_pair = {ns[31:0], ds[31:0]};
   endfunction

   // configuration
   logic signed [15:0] sharpen_ff;
   logic [15:0]        dehalo_ff;
   logic [31:0]        smin_ff, smax_ff, hfloor_ff;
   logic               degrid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sharpen_ff <= '0;
         dehalo_ff  <= '0;
         smin_ff    <= '0;
         smax_ff    <= '0;
         hfloor_ff  <= '0;
         degrid_ff  <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            ssdg_pkg::REG_SHARPEN_STRENGTH: sharpen_ff <= csr_wdata[15:0];
            ssdg_pkg::REG_DEHALO_STRENGTH:  dehalo_ff  <= csr_wdata[15:0];
            ssdg_pkg::REG_SIGMA_MIN_SQ:     smin_ff    <= csr_wdata;
            ssdg_pkg::REG_SIGMA_MAX_SQ:     smax_ff    <= csr_wdata;
            ssdg_pkg::REG_HALO_FLOOR_SQ:    hfloor_ff  <= csr_wdata;
            ssdg_pkg::REG_DEGRID_ENABLE:    degrid_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic valid_ff [0:LAST];
   logic adv;

   assign adv        = !valid_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k <= LAST; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // stage 0: capture
   logic signed [31:0] bre0_ff, bim0_ff, gre0_ff, gim0_ff;
   logic signed [23:0] gfr0_ff;
   logic [15:0]        ws0_ff;
   logic [15:0]        wd_ff [0:38];

   // grid correction, remainder, power
   logic signed [39:0] gcr_ff [1:59];
   logic signed [39:0] gci_ff [1:59];
   logic signed [31:0] bre1_ff, bim1_ff;
   logic signed [32:0] sw_ff [1:55];
   logic signed [31:0] crr_ff [2:58];
   logic signed [31:0] cri_ff [2:58];
   logic [63:0]        sqr3_ff, sqi3_ff;
   logic [47:0]        p4_ff;
   logic [48:0]        da5_ff, db5_ff, df5_ff;
   logic [47:0]        p5_ff;
   logic [31:0]        smax5_ff;
   logic [31:0]        na6_ff, da6_ff, nb6_ff, db6_ff, nf6_ff, df6_ff;

   logic               degrid_eff;
   logic signed [55:0] gpr_in, gpi_in;
   logic signed [40:0] dr_in, di_in;
   logic [63:0]        psum_in;
   logic [47:0]        p_in;
   logic [63:0]        na_pair, nb_pair, nf_pair;

   always_comb begin
      degrid_eff = degrid_ff && !(sharpen_ff == 16'sd0 && dehalo_ff == 16'd0);
      gpr_in     = gre0_ff * $signed(gfr0_ff);
      gpi_in     = gim0_ff * $signed(gfr0_ff);
      dr_in      = 41'(bre1_ff) - 41'(gcr_ff[1]);
      di_in      = 41'(bim1_ff) - 41'(gci_ff[1]);
      psum_in    = sqr3_ff + sqi3_ff;
      p_in       = (psum_in[63:16] == 48'd0) ? 48'd1 : psum_in[63:16];
      na_pair    = norm_pair({1'b0, p5_ff}, da5_ff);
      nb_pair    = norm_pair({17'd0, smax5_ff}, db5_ff);
      nf_pair    = norm_pair({1'b0, p5_ff}, df5_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bre0_ff  <= req_tdata[31:0];
         bim0_ff  <= req_tdata[63:32];
         gre0_ff  <= req_tdata[95:64];
         gim0_ff  <= req_tdata[127:96];
         gfr0_ff  <= req_tdata[151:128];
         ws0_ff   <= req_tdata[167:152];
         wd_ff[0] <= req_tdata[183:168];
         for (int k = 1; k <= 38; k++) wd_ff[k] <= wd_ff[k-1];

         gcr_ff[1] <= degrid_eff ? gpr_in[55:16] : 40'sd0;
         gci_ff[1] <= degrid_eff ? gpi_in[55:16] : 40'sd0;
         for (int k = 2; k <= 59; k++) begin
            gcr_ff[k] <= gcr_ff[k-1];
            gci_ff[k] <= gci_ff[k-1];
         end
         bre1_ff  <= bre0_ff;
         bim1_ff  <= bim0_ff;
         sw_ff[1] <= sharpen_ff * $signed({1'b0, ws0_ff});
         for (int k = 2; k <= 55; k++) sw_ff[k] <= sw_ff[k-1];

         crr_ff[2] <= sat32(42'(dr_in));
         cri_ff[2] <= sat32(42'(di_in));
         for (int k = 3; k <= 58; k++) begin
            crr_ff[k] <= crr_ff[k-1];
            cri_ff[k] <= cri_ff[k-1];
         end

         sqr3_ff  <= $unsigned(64'(crr_ff[2]) * 64'(crr_ff[2]));
         sqi3_ff  <= $unsigned(64'(cri_ff[2]) * 64'(cri_ff[2]));
         p4_ff    <= p_in;
         da5_ff   <= {1'b0, p4_ff} + {17'd0, smin_ff};
         db5_ff   <= {1'b0, p4_ff} + {17'd0, smax_ff};
         df5_ff   <= {1'b0, p4_ff} + {17'd0, hfloor_ff};
         p5_ff    <= p4_ff;
         smax5_ff <= smax_ff;
         na6_ff   <= na_pair[63:32];
         da6_ff   <= na_pair[31:0];
         nb6_ff   <= nb_pair[63:32];
         db6_ff   <= nb_pair[31:0];
         nf6_ff   <= nf_pair[63:32];
         df6_ff   <= nf_pair[31:0];
      end
   end

   // fractions, stages 7..38
   logic [31:0] a38, b38, f38;

   ssdg_div #(.DW(ssdg_pkg::FRAC_DW), .QW(ssdg_pkg::FRAC_QW)) u_div_a (
      .clock(clock), .en(adv), .rem_in(na6_ff), .den_in(da6_ff), .quot(a38));
   ssdg_div #(.DW(ssdg_pkg::FRAC_DW), .QW(ssdg_pkg::FRAC_QW)) u_div_b (
      .clock(clock), .en(adv), .rem_in(nb6_ff), .den_in(db6_ff), .quot(b38));
   ssdg_div #(.DW(ssdg_pkg::FRAC_DW), .QW(ssdg_pkg::FRAC_QW)) u_div_f (
      .clock(clock), .en(adv), .rem_in(nf6_ff), .den_in(df6_ff), .quot(f38));

   // dehalo term and divisor
   logic [27:0] f4_39_ff;
   logic [31:0] dw39_ff;
   logic [31:0] t40_ff;
   logic [32:0] den41_ff;
   logic [63:0] ab_in;
   logic [59:0] tp_in;
   logic [12:0] gd54;
   logic [12:0] gd_ff [55:57];

   assign ab_in = a38 * b38;
   assign tp_in = dw39_ff * f4_39_ff;

   // square root, stage 39 holds r, stages 40..55 one result bit each
   logic [31:0] sv_ff [0:16];
   logic [32:0] sr_ff [0:16];
   logic [31:0] sv_in [1:16];
   logic [32:0] sr_in [1:16];
   logic [32:0] sq_bit [1:16];
   logic [32:0] sq_try [1:16];

   always_comb begin
      for (int j = 1; j <= 16; j++) begin
         sq_bit[j] = 33'd1 << (2 * (16 - j));
         sq_try[j] = sr_ff[j-1] + sq_bit[j];
         if ({1'b0, sv_ff[j-1]} >= sq_try[j]) begin
            sv_in[j] = sv_ff[j-1] - sq_try[j][31:0];
            sr_in[j] = (sr_ff[j-1] >> 1) + sq_bit[j];
         end else begin
            sv_in[j] = sv_ff[j-1];
            sr_in[j] = sr_ff[j-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sv_ff[0] <= ab_in[63:32];
         sr_ff[0] <= '0;
         for (int j = 1; j <= 16; j++) begin
            sv_ff[j] <= sv_in[j];
            sr_ff[j] <= sr_in[j];
         end
         f4_39_ff <= f38[31:4];
         dw39_ff  <= dehalo_ff * wd_ff[38];
         t40_ff   <= tp_in[59:28];
         den41_ff <= 33'h0_1000_0000 + {1'b0, t40_ff};
         gd_ff[55] <= gd54;
         gd_ff[56] <= gd_ff[55];
         gd_ff[57] <= gd_ff[56];
      end
   end

   ssdg_div #(.DW(ssdg_pkg::GD_DW), .QW(ssdg_pkg::GD_QW)) u_div_gd (
      .clock(clock), .en(adv), .rem_in(33'h0_0800_0000), .den_in(den41_ff), .quot(gd54));

   // gains and output
   logic signed [49:0] sp56_ff;
   logic signed [15:0] gs57_ff;
   logic signed [29:0] gt58_ff;
   logic signed [61:0] yr59_ff, yi59_ff;
   logic signed [31:0] yr60_ff, yi60_ff;
   logic signed [18:0] gs_in;
   logic signed [41:0] sr_sum_in, si_sum_in;

   always_comb begin
      gs_in = 19'sd4096 + 19'($signed(sp56_ff[49:32]));
      if (gs_in[18:15] != {4{gs_in[18]}}) begin
         gs_in = gs_in[18] ? -19'sd32768 : 19'sd32767;
      end
      sr_sum_in = 42'($signed(yr59_ff[61:24])) + 42'(gcr_ff[59]);
      si_sum_in = 42'($signed(yi59_ff[61:24])) + 42'(gci_ff[59]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp56_ff <= sw_ff[55] * $signed({1'b0, sr_ff[16][15:0]});
         gs57_ff <= gs_in[15:0];
         gt58_ff <= gs57_ff * $signed({1'b0, gd_ff[57]});
         yr59_ff <= crr_ff[58] * gt58_ff;
         yi59_ff <= cri_ff[58] * gt58_ff;
         yr60_ff <= sat32(sr_sum_in);
         yi60_ff <= sat32(si_sum_in);
      end
   end

   assign rsp_tdata = {yi60_ff, yr60_ff};

endmodule
`default_nettype wire
